// ===== src/prwc_pkg.sv =====
// Package for the peer replay window check: sizes, payload words and the
// command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package prwc_pkg;

    localparam int PEER_SLOTS  = 8;
    localparam int WINDOW_BITS = 31;

    localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PEER_SLOTS + 1);
    localparam int SH_W   = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int FLAG_W = WINDOW_BITS + 1;

    typedef struct packed {
        logic [63:0] peer_node_id;
        logic [31:0] message_id;
        logic        over_stream_link;
    } msg_t;

    typedef struct packed {
        logic       is_duplicate;
        logic [2:0] peer_slot;
        logic       new_peer;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic hit_take;
        logic alloc;
        logic update;
        logic emit_stream;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stream;
        logic scan_hit;
        logic scan_last;
    } ctrl_stat_t;

endpackage

// ===== src/prwc_ctrl.sv =====
// Controller of the peer replay window check: sequences the recency scan,
// slot allocation and window update of one word, and lets a stream-link word pass.
// Depends on prwc_pkg.
module prwc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  prwc_pkg::ctrl_stat_t stat,
    output prwc_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import prwc_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        ALLOC,
        UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (stat.stream)
                begin
                    cmd.emit_stream = 1'b1;
                    done_next       = 1'b1;
                    state_next      = IDLE;
                end
                else if (stat.scan_hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = UPDATE;
                end
                else if (stat.scan_last)
                begin
                    state_next = ALLOC;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = UPDATE;
            end
            UPDATE:
            begin
                cmd.update = 1'b1;
                done_next  = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != IDLE);
    assign done = done_reg;

endmodule

// ===== src/prwc_datapath.sv =====
// Datapath of the peer replay window check: slot tables, recency order,
// lookup compare, allocation and the sliding window update.
// Depends on prwc_pkg.
module prwc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  prwc_pkg::msg_t       message,
    input  prwc_pkg::ctrl_cmd_t  cmd,
    output prwc_pkg::ctrl_stat_t stat,
    output prwc_pkg::result_t    result
);
    import prwc_pkg::*;

    logic [63:0]       node_id_reg [PEER_SLOTS];
    logic [31:0]       highest_reg [PEER_SLOTS];
    logic [FLAG_W-1:0] flags_reg   [PEER_SLOTS];
    logic [SLOT_W-1:0] order_reg   [PEER_SLOTS];

    logic [CNT_W-1:0]  in_use_reg;
    logic [CNT_W-1:0]  in_use_next;

    msg_t              msg_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              fresh_reg;
    result_t           res_reg;

    logic [SLOT_W-1:0]      scan_slot;
    logic                   table_full;
    logic [SLOT_W-1:0]      alloc_pos;
    logic [SLOT_W-1:0]      alloc_slot;

    logic                   synced;
    logic [WINDOW_BITS-1:0] win;
    logic [31:0]            delta;
    logic [31:0]            lag;
    logic [31:0]            delta_m1;
    logic [31:0]            lag_m1;
    logic [WINDOW_BITS:0]   ext_shift;
    logic [WINDOW_BITS-1:0] old_bit;
    logic [WINDOW_BITS-1:0] win_new;
    logic                   set_highest;
    logic                   write_flags;
    logic                   dup;

    assign scan_slot  = order_reg[pos_reg];
    assign table_full = (in_use_reg == CNT_W'(PEER_SLOTS));
    assign alloc_pos  = table_full ? SLOT_W'(PEER_SLOTS - 1) : in_use_reg[SLOT_W-1:0];
    assign alloc_slot = table_full ? order_reg[PEER_SLOTS - 1] : in_use_reg[SLOT_W-1:0];

    assign stat.stream    = msg_reg.over_stream_link;
    assign stat.scan_hit  = (CNT_W'(pos_reg) < in_use_reg)
                            && (node_id_reg[scan_slot] == msg_reg.peer_node_id);
    assign stat.scan_last = ((CNT_W'(pos_reg) + CNT_W'(1)) >= in_use_reg);

    assign synced    = fresh_reg ? 1'b0 : flags_reg[slot_reg][WINDOW_BITS];
    assign win       = flags_reg[slot_reg][WINDOW_BITS-1:0];
    assign delta     = msg_reg.message_id - highest_reg[slot_reg];
    assign lag       = 32'd0 - delta;
    assign delta_m1  = delta - 32'd1;
    assign lag_m1    = lag - 32'd1;
    assign ext_shift = {win, 1'b1} << delta_m1[SH_W-1:0];
    assign old_bit   = WINDOW_BITS'(1) << lag_m1[SH_W-1:0];

    always_comb
    begin
        win_new     = '0;
        set_highest = 1'b0;
        write_flags = 1'b1;
        dup         = 1'b0;
        if (!synced)
        begin
            set_highest = 1'b1;
        end
        else if (delta == 32'd0)
        begin
            dup         = 1'b1;
            write_flags = 1'b0;
        end
        else if (!delta[31])
        begin
            set_highest = 1'b1;
            if (delta < 32'(WINDOW_BITS))
            begin
                win_new = ext_shift[WINDOW_BITS-1:0];
            end
        end
        else if (lag <= 32'(WINDOW_BITS))
        begin
            if ((win & old_bit) != '0)
            begin
                dup         = 1'b1;
                write_flags = 1'b0;
            end
            else
            begin
                win_new = win | old_bit;
            end
        end
        else
        begin
            set_highest = 1'b1;
        end
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.alloc && !table_full)
        begin
            in_use_next = in_use_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            msg_reg <= message;
            pos_reg <= '0;
        end
        if (cmd.scan_next)
        begin
            pos_reg <= pos_reg + SLOT_W'(1);
        end
        if (cmd.hit_take)
        begin
            slot_reg  <= scan_slot;
            fresh_reg <= 1'b0;
        end
        if (cmd.alloc)
        begin
            pos_reg                 <= alloc_pos;
            slot_reg                <= alloc_slot;
            fresh_reg               <= 1'b1;
            node_id_reg[alloc_slot] <= msg_reg.peer_node_id;
        end
        if (cmd.update)
        begin
            if (set_highest)
            begin
                highest_reg[slot_reg] <= msg_reg.message_id;
            end
            if (write_flags)
            begin
                flags_reg[slot_reg] <= {1'b1, win_new};
            end
            for (int k = 1; k < PEER_SLOTS; k++)
            begin
                if (SLOT_W'(k) <= pos_reg)
                begin
                    order_reg[k] <= order_reg[k - 1];
                end
            end
            order_reg[0]         <= slot_reg;
            res_reg.is_duplicate <= dup;
            res_reg.peer_slot    <= 3'(slot_reg);
            res_reg.new_peer     <= fresh_reg;
        end
        if (cmd.emit_stream)
        begin
            res_reg <= '0;
        end
    end

    assign result = res_reg;

endmodule

// ===== src/peer_replay_window_check.sv =====
// Top level of the peer replay window check: joins the controller and the
// datapath and carries the port checks.
// Depends on prwc_pkg, prwc_ctrl and prwc_datapath.
//
//  channel   handshake             payload
//  message   start, busy           message (msg_t)
//  result    done (one cycle)      result (result_t)
//
// A word is taken at an edge with start high and busy low; busy stays high
// until its result is shown, and the next word may be taken in that cycle.
// A stream-link word skips the scan; any other is scanned in recency order,
// one slot per cycle, until its peer is found or the slots in use run out,
// then gets a slot (the least recent one when the table is full) and its window update.
// Reset empties the slot table at once; the result has no back-pressure.
module peer_replay_window_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  prwc_pkg::msg_t    message,
    output logic              busy,
    output logic              done,
    output prwc_pkg::result_t result
);
    import prwc_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    prwc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    prwc_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (message),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fresh_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.new_peer) |-> !result.is_duplicate)
        else $error("fresh peer reported as duplicate");

endmodule

// ===== tb/peer_replay_window_check_tb.sv =====
// Self-checking testbench for peer_replay_window_check: directed and random message words,
// each verdict predicted from a local copy of the peer table and replay windows.
// Depends on prwc_pkg and the peer_replay_window_check top level.
module peer_replay_window_check_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import prwc_pkg::*;

    localparam logic [63:0] WIN_MASK = (64'd1 << WINDOW_BITS) - 64'd1;
    localparam logic [63:0] SYNC_BIT = 64'd1 << WINDOW_BITS;
    localparam int POOL_SIZE = 12;
    localparam int REPORT_LIMIT = 10;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    msg_t    message = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic [63:0]       node_tab[PEER_SLOTS];
    logic [31:0]       highest_tab[PEER_SLOTS];
    logic [FLAG_W-1:0] flag_tab[PEER_SLOTS];
    logic [SLOT_W-1:0] recency_tab[PEER_SLOTS];
    logic [CNT_W-1:0]  slots_used = '0;

    result_t pending_verdicts[$];
    int      mismatches = 0;

    logic [63:0] pool_node[POOL_SIZE];
    logic [31:0] pool_last[POOL_SIZE];

    peer_replay_window_check u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .message (message),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("peer_replay_window_check regression: fail");
        $finish;
    end

    function automatic result_t predict_verdict(msg_t m);
        result_t           r;
        int                pos;
        int                k;
        logic [SLOT_W-1:0] slot;
        bit                found;
        logic [63:0]       win;
        logic [63:0]       flags_next;
        logic [63:0]       bit_mask;
        logic [31:0]       delta;
        logic [31:0]       lag;
        r = '0;
        if (m.over_stream_link)
        begin
            return r;
        end
        found = 1'b0;
        slot = '0;
        for (pos = 0; pos < slots_used; pos++)
        begin
            slot = recency_tab[pos];
            if (node_tab[slot] == m.peer_node_id)
            begin
                found = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            if (slots_used >= PEER_SLOTS)
            begin
                pos = PEER_SLOTS - 1;
                slot = recency_tab[pos];
            end
            else
            begin
                pos = slots_used;
                slot = SLOT_W'(slots_used);
                slots_used = slots_used + CNT_W'(1);
            end
            node_tab[slot] = m.peer_node_id;
            highest_tab[slot] = '0;
            flag_tab[slot] = '0;
        end
        for (k = pos; k > 0; k--)
        begin
            recency_tab[k] = recency_tab[k - 1];
        end
        recency_tab[0] = slot;
        r.peer_slot = 3'(slot);
        r.new_peer = !found;

        win = 64'(flag_tab[slot]) & WIN_MASK;
        if (!flag_tab[slot][WINDOW_BITS])
        begin
            flags_next = SYNC_BIT;
            flag_tab[slot] = flags_next[FLAG_W-1:0];
            highest_tab[slot] = m.message_id;
            return r;
        end
        delta = m.message_id - highest_tab[slot];
        if (delta == 32'd0)
        begin
            r.is_duplicate = 1'b1;
            return r;
        end
        if (delta < 32'h8000_0000)
        begin
            if (delta < WINDOW_BITS)
            begin
                win = (((win << 1) | 64'd1) << (delta - 32'd1)) & WIN_MASK;
            end
            else
            begin
                win = '0;
            end
            highest_tab[slot] = m.message_id;
        end
        else
        begin
            lag = 32'd0 - delta;
            if (lag <= WINDOW_BITS)
            begin
                bit_mask = 64'd1 << (lag - 32'd1);
                if ((win & bit_mask) != 64'd0)
                begin
                    r.is_duplicate = 1'b1;
                    return r;
                end
                win = win | bit_mask;
            end
            else
            begin
                win = '0;
                highest_tab[slot] = m.message_id;
            end
        end
        flags_next = SYNC_BIT | win;
        flag_tab[slot] = flags_next[FLAG_W-1:0];
        return r;
    endfunction

    function automatic msg_t make_msg(logic [63:0] node, logic [31:0] id, logic stream);
        msg_t m;
        m.peer_node_id = node;
        m.message_id = id;
        m.over_stream_link = stream;
        return m;
    endfunction

    function automatic int pick_gap(int idle_pct);
        int gap;
        gap = 0;
        while (gap < 100 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        return gap;
    endfunction

    // Called at a rising edge; returns at the edge that takes the word, or after the gap.
    task automatic send_message(msg_t m, int idle_pct);
        int gap;
        message <= m;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        pending_verdicts.push_back(predict_verdict(m));
        gap = pick_gap(idle_pct);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_verdicts();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result: dup=%0d slot=%0d new=%0d",
                             result.is_duplicate, result.peer_slot, result.new_peer);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.is_duplicate !== want.is_duplicate
                    || result.peer_slot !== want.peer_slot
                    || result.new_peer !== want.new_peer)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch (dup slot new): expected %0d %0d %0d, got %0d %0d %0d",
                                 want.is_duplicate, want.peer_slot, want.new_peer,
                                 result.is_duplicate, result.peer_slot, result.new_peer);
                    end
                end
            end
        end
    end

    task automatic test_stream_link();
        send_message(make_msg(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0);
        send_message(make_msg(64'h0, 32'h0, 1'b1), 0);
    endtask

    task automatic test_window_rules();
        send_message(make_msg(64'h0, 32'd0, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd0, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd1, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd0, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd32, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd1, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd1, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd0, 1'b0), 0);
        send_message(make_msg(64'h0, 32'h8000_0000, 1'b0), 0);
        send_message(make_msg(64'h0, 32'hFFFF_FFFF, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd0, 1'b0), 0);
        send_message(make_msg(64'h0, 32'hFFFF_FFFF, 1'b0), 0);
        send_message(make_msg(64'h0, 32'd30, 1'b0), 0);
    endtask

    task automatic test_table_replacement();
        int n;
        send_message(make_msg(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0), 0);
        for (n = 1; n <= 6; n++)
        begin
            send_message(make_msg(64'(n), 32'(n), 1'b0), 0);
        end
        send_message(make_msg(64'h0, 32'd31, 1'b0), 0);
        send_message(make_msg(64'd7, 32'd7, 1'b0), 0);
        send_message(make_msg(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0), 0);
    endtask

    function automatic logic [31:0] next_message_id(logic [31:0] last);
        case ($urandom_range(0, 11))
            0:       return last;
            1, 2:    return last + 32'($urandom_range(1, 4));
            3:       return last + 32'($urandom_range(5, 40));
            4:       return last - 32'($urandom_range(1, 31));
            5:       return last - 32'($urandom_range(1, 6));
            6:       return last + 32'h8000_0000;
            7:       return last - 32'($urandom_range(32, 1000));
            8:       return last + 32'(WINDOW_BITS);
            9:       return last - 32'(WINDOW_BITS + 1);
            10:      return $urandom;
            default: return last + {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic test_random_traffic(int idle_pct, int count);
        int          n;
        int          sel;
        logic [31:0] id;
        msg_t        m;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                m = make_msg({$urandom, $urandom}, $urandom, 1'b1);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                m = make_msg({$urandom, $urandom}, $urandom, 1'b0);
            end
            else
            begin
                sel = $urandom_range(0, ($urandom_range(0, 1) == 1) ? 5 : POOL_SIZE - 1);
                if ($urandom_range(0, 49) == 0)
                begin
                    pool_node[sel] = {$urandom, $urandom};
                    pool_last[sel] = $urandom;
                end
                id = next_message_id(pool_last[sel]);
                if (id - pool_last[sel] < 32'h8000_0000)
                begin
                    pool_last[sel] = id;
                end
                m = make_msg(pool_node[sel], id, 1'b0);
            end
            send_message(m, idle_pct);
            if ($urandom_range(0, 199) == 0)
            begin
                wait_all_verdicts();
            end
        end
        wait_all_verdicts();
    endtask

    initial
    begin
        int p;
        for (p = 0; p < POOL_SIZE; p++)
        begin
            pool_node[p] = {$urandom, $urandom};
            pool_last[p] = $urandom;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stream_link();
        test_window_rules();
        test_table_replacement();
        wait_all_verdicts();
        test_random_traffic(0, 450);
        test_random_traffic(80, 450);
        test_random_traffic(14, 450);
        repeat (30) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            mismatches++;
            $display("%0d results never arrived", pending_verdicts.size());
        end
        if (mismatches == 0)
        begin
            $display("peer_replay_window_check regression: pass");
        end
        else
        begin
            $display("peer_replay_window_check regression: fail");
        end
        $finish;
    end

endmodule
